@@ sv/ocl_pkg.sv @@
package ocl_pkg;

	localparam int COORD_W = 32;
	localparam int DEPTH_W = 4;
	localparam int ID_W = 25;
	localparam int CFG_IDX_W = 3;
	localparam int NUM_AXES = 3;
	localparam int MAX_DEPTH_DEF = 8;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [DEPTH_W-1:0] depth_t;
	typedef logic [ID_W-1:0] cell_id_t;
	typedef logic [2:0] octant_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_X_LOW  = 3'd0,
		CFG_X_HIGH = 3'd1,
		CFG_Y_LOW  = 3'd2,
		CFG_Y_HIGH = 3'd3,
		CFG_Z_LOW  = 3'd4,
		CFG_Z_HIGH = 3'd5
	} cfg_idx_t;

	localparam coord_t BOX_LOW_RST = 32'sd0;
	localparam coord_t BOX_HIGH_RST = 32'sd65536;

	// Octant bit that each axis (x, y, z) sets when it takes the upper half.
	localparam logic [1:0] AXIS_BIT [NUM_AXES] = '{2'd0, 2'd2, 2'd1};

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic emit;
	} ocl_cmd_t;

	typedef struct packed {
		logic lvl_done;
	} ocl_sts_t;

endpackage

@@ sv/ocl_ctrl.sv @@
module ocl_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  ocl_pkg::ocl_sts_t sts,
	output ocl_pkg::ocl_cmd_t cmd
);
	import ocl_pkg::*;

	state_t state_q, state_d;
	logic out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d = state_q;
		out_valid_d = out_valid_q && !out_ready;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (!sts.lvl_done) begin
					cmd.step = 1'b1;
				end else if (!out_valid_q || out_ready) begin
					cmd.emit = 1'b1;
					out_valid_d = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

@@ sv/ocl_dp.sv @@
module ocl_dp #(
	parameter int MAX_DEPTH = ocl_pkg::MAX_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ocl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ocl_pkg::COORD_W-1:0]      cfg_data,
	input  logic signed [ocl_pkg::COORD_W-1:0] pos_x,
	input  logic signed [ocl_pkg::COORD_W-1:0] pos_y,
	input  logic signed [ocl_pkg::COORD_W-1:0] pos_z,
	input  logic [ocl_pkg::DEPTH_W-1:0]      target_depth,
	input  ocl_pkg::ocl_cmd_t                cmd,
	output ocl_pkg::ocl_sts_t                sts,
	output logic [ocl_pkg::ID_W-1:0]         cell_id,
	output logic                             depth_error
);
	import ocl_pkg::*;

	localparam depth_t MAX_D = DEPTH_W'(MAX_DEPTH);

	coord_t box_lo_q [NUM_AXES];
	coord_t box_hi_q [NUM_AXES];
	coord_t lo_q [NUM_AXES];
	coord_t hi_q [NUM_AXES];
	coord_t pos_q [NUM_AXES];
	coord_t pos_in [NUM_AXES];
	depth_t cnt_q;
	cell_id_t id_q;
	logic err_q;
	cell_id_t cell_id_q;
	logic depth_error_q;

	logic signed [COORD_W:0] sum [NUM_AXES];
	logic signed [COORD_W:0] twop [NUM_AXES];
	logic upper [NUM_AXES];
	octant_t oct;

	assign pos_in[0] = pos_x;
	assign pos_in[1] = pos_y;
	assign pos_in[2] = pos_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				box_lo_q[a] <= BOX_LOW_RST;
				box_hi_q[a] <= BOX_HIGH_RST;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_X_LOW:  box_lo_q[0] <= cfg_data;
				CFG_X_HIGH: box_hi_q[0] <= cfg_data;
				CFG_Y_LOW:  box_lo_q[1] <= cfg_data;
				CFG_Y_HIGH: box_hi_q[1] <= cfg_data;
				CFG_Z_LOW:  box_lo_q[2] <= cfg_data;
				CFG_Z_HIGH: box_hi_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// The midpoint is the 33-bit sum shifted right, which rounds toward minus infinity.
	always_comb begin
		oct = '0;
		for (int a = 0; a < NUM_AXES; a++) begin
			sum[a] = {lo_q[a][COORD_W-1], lo_q[a]} + {hi_q[a][COORD_W-1], hi_q[a]};
			twop[a] = {pos_q[a], 1'b0};
			upper[a] = !(twop[a] < sum[a]);
			oct[AXIS_BIT[a]] = upper[a];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				lo_q[a] <= box_lo_q[a];
				hi_q[a] <= box_hi_q[a];
				pos_q[a] <= pos_in[a];
			end
			id_q <= ID_W'(1);
			if (target_depth > MAX_D) begin
				cnt_q <= MAX_D;
				err_q <= 1'b1;
			end else begin
				cnt_q <= target_depth;
				err_q <= 1'b0;
			end
		end else if (cmd.step) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				if (upper[a]) begin
					lo_q[a] <= sum[a][COORD_W:1];
				end else begin
					hi_q[a] <= sum[a][COORD_W:1];
				end
			end
			id_q <= {id_q[ID_W-4:0], oct};
			cnt_q <= cnt_q - depth_t'(1);
		end
		if (cmd.emit) begin
			cell_id_q <= id_q;
			depth_error_q <= err_q;
		end
	end

	assign sts.lvl_done = (cnt_q == '0);
	assign cell_id = cell_id_q;
	assign depth_error = depth_error_q;

endmodule

@@ sv/octree_point_cell_locate.sv @@
// Octree point cell locator.
// Input channel (in_valid/in_ready) carries a point pos_x, pos_y, pos_z in
// signed Q15.16 and a target_depth; output channel (out_valid/out_ready)
// carries the cell_id of the cell holding the point and a depth_error flag.
// The root box is set through the write port cfg_we/cfg_index/cfg_data;
// the user must write it only while the block is idle, which the block
// itself does not enforce. Writes to unknown indexes are ignored.
// The box is loaded at the edge that accepts a transfer. Then the shared
// bisection unit halves the box once per level of the clipped depth (at
// most MAX_DEPTH), and the id then moves into the output register.
// Points are processed one at a time; the output register lets a new point
// start while the previous result still waits for out_ready.
// If the receiver stalls, a finished result waits in the bisection unit
// until the output register empties, and no new point is accepted.
// Reset clears the control state and returns the box to [0, 1.0] per axis.
module octree_point_cell_locate #(
	parameter int MAX_DEPTH = ocl_pkg::MAX_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [ocl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ocl_pkg::COORD_W-1:0]        cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [ocl_pkg::COORD_W-1:0] pos_x,
	input  logic signed [ocl_pkg::COORD_W-1:0] pos_y,
	input  logic signed [ocl_pkg::COORD_W-1:0] pos_z,
	input  logic [ocl_pkg::DEPTH_W-1:0]        target_depth,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [ocl_pkg::ID_W-1:0]           cell_id,
	output logic                               depth_error
);
	import ocl_pkg::*;

	ocl_cmd_t cmd;
	ocl_sts_t sts;

	ocl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ocl_dp #(
		.MAX_DEPTH (MAX_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.target_depth (target_depth),
		.cmd          (cmd),
		.sts          (sts),
		.cell_id      (cell_id),
		.depth_error  (depth_error)
	);

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import ocl_pkg::*;

	localparam int MAX_LEVELS = MAX_DEPTH_DEF;
	localparam int SETTLE_CYCLES = MAX_DEPTH_DEF + 4;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int OCTANT_POS [3] = '{0, 2, 1};
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
	localparam coord_t COORD_MIN = 32'sh8000_0000;
	localparam coord_t COORD_MAX = 32'sh7FFF_FFFF;

	typedef struct {
		coord_t x;
		coord_t y;
		coord_t z;
		depth_t depth;
	} point_req_t;

	typedef struct {
		cell_id_t cell_num;
		logic depth_err;
	} cell_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [COORD_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	coord_t pos_x = '0;
	coord_t pos_y = '0;
	coord_t pos_z = '0;
	depth_t target_depth = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	cell_id_t cell_id;
	logic depth_error;

	coord_t box_low [3] = '{32'sd0, 32'sd0, 32'sd0};
	coord_t box_high [3] = '{32'sd65536, 32'sd65536, 32'sd65536};

	point_req_t pending_points [$];
	cell_result_t cells_due [$];
	point_req_t next_point;
	cell_result_t seen_cell;
	int issue_count = 0;
	int accept_count = 0;
	int mismatches = 0;
	bit steady = 1'b0;
	bit long_hold_req = 1'b0;
	bit long_hold_done = 1'b0;
	int hold_left = 0;

	octree_point_cell_locate dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.pos_z(pos_z),
		.target_depth(target_depth),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cell_id(cell_id),
		.depth_error(depth_error)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic cell_result_t locate_cell(coord_t px, coord_t py, coord_t pz,
			depth_t req);
		coord_t pt [3];
		coord_t lo [3];
		coord_t hi [3];
		logic signed [33:0] sum;
		logic signed [33:0] twice;
		logic [2:0] octant;
		logic [63:0] id;
		int levels;
		int lvl;
		int a;
		cell_result_t res;
		pt[0] = px;
		pt[1] = py;
		pt[2] = pz;
		lo = box_low;
		hi = box_high;
		levels = req;
		res.depth_err = 1'b0;
		if (levels > MAX_LEVELS) begin
			levels = MAX_LEVELS;
			res.depth_err = 1'b1;
		end
		id = 64'd1;
		for (lvl = 0; lvl < levels; lvl++) begin
			octant = '0;
			for (a = 0; a < 3; a++) begin
				sum = lo[a];
				sum = sum + hi[a];
				twice = pt[a];
				twice = twice <<< 1;
				if (twice < sum) begin
					hi[a] = sum[32:1];
				end else begin
					lo[a] = sum[32:1];
					octant[OCTANT_POS[a]] = 1'b1;
				end
			end
			id = (id << 3) | octant;
		end
		res.cell_num = id[ID_W-1:0];
		return res;
	endfunction

	function automatic coord_t pick_coord(coord_t a, coord_t b);
		logic signed [33:0] lo_w;
		logic signed [33:0] hi_w;
		logic signed [33:0] sum;
		logic [63:0] span;
		logic [63:0] val;
		int pick;
		pick = $urandom_range(9);
		lo_w = (a < b) ? a : b;
		hi_w = (a < b) ? b : a;
		sum = lo_w + hi_w;
		if (pick <= 4) begin
			span = 64'(hi_w - lo_w) + 64'd1;
			val = 64'(lo_w) + ({$urandom, $urandom} % span);
		end else if (pick <= 6) begin
			val = {32'd0, $urandom};
		end else if (pick == 7) begin
			val = 64'(sum >>> 1) + 64'($urandom_range(2)) - 64'd1;
		end else if (pick == 8) begin
			val = 64'($urandom_range(1) ? lo_w : hi_w) + 64'($urandom_range(2)) - 64'd1;
		end else begin
			case ($urandom_range(3))
				0: val = 64'(COORD_MIN);
				1: val = 64'(COORD_MAX);
				2: val = 64'd0;
				default: val = '1;
			endcase
		end
		return val[31:0];
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input coord_t value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			CFG_X_LOW: box_low[0] = value;
			CFG_X_HIGH: box_high[0] = value;
			CFG_Y_LOW: box_low[1] = value;
			CFG_Y_HIGH: box_high[1] = value;
			CFG_Z_LOW: box_low[2] = value;
			CFG_Z_HIGH: box_high[2] = value;
			default: ;
		endcase
	endtask

	task automatic close_writes();
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_box(input coord_t xl, input coord_t xh, input coord_t yl,
			input coord_t yh, input coord_t zl, input coord_t zh);
		write_reg(CFG_X_LOW, xl);
		write_reg(CFG_X_HIGH, xh);
		write_reg(CFG_Y_LOW, yl);
		write_reg(CFG_Y_HIGH, yh);
		write_reg(CFG_Z_LOW, zl);
		write_reg(CFG_Z_HIGH, zh);
		close_writes();
	endtask

	task automatic queue_point(input coord_t x, input coord_t y, input coord_t z,
			input depth_t d);
		pending_points.push_back('{x, y, z, d});
	endtask

	task automatic queue_random_points(input int count);
		int n;
		for (n = 0; n < count; n++) begin
			queue_point(pick_coord(box_low[0], box_high[0]), pick_coord(box_low[1], box_high[1]),
				pick_coord(box_low[2], box_high[2]), depth_t'($urandom_range(15)));
		end
	endtask

	task automatic drain();
		while (pending_points.size() != 0 || accept_count != issue_count
				|| cells_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Sender: a new point is offered only once the previous one has been transferred.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || accept_count == issue_count) begin
			if (pending_points.size() > 0 && (steady || $urandom_range(99) >= 24)) begin
				next_point = pending_points.pop_front();
				pos_x <= next_point.x;
				pos_y <= next_point.y;
				pos_z <= next_point.z;
				target_depth <= next_point.depth;
				in_valid <= 1'b1;
				issue_count++;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (long_hold_req && !long_hold_done) begin
			hold_left = LONG_HOLD_CYCLES;
			long_hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (!steady && $urandom_range(99) < 24) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				cells_due.push_back(locate_cell(pos_x, pos_y, pos_z, target_depth));
				accept_count <= accept_count + 1;
			end
			if (out_valid && out_ready) begin
				if (cells_due.size() == 0) begin
					$display("%0t: unexpected result, cell_id %h depth_error %b", $time,
						cell_id, depth_error);
					mismatches++;
				end else begin
					seen_cell = cells_due.pop_front();
					if (cell_id !== seen_cell.cell_num) begin
						$display("%0t: cell_id mismatch, expected %h, actual %h", $time,
							seen_cell.cell_num, cell_id);
						mismatches++;
					end
					if (depth_error !== seen_cell.depth_err) begin
						$display("%0t: depth_error mismatch, expected %b, actual %b", $time,
							seen_cell.depth_err, depth_error);
						mismatches++;
					end
				end
			end
		end
	end

	initial begin
		coord_t lo_v [3];
		coord_t hi_v [3];
		int phase;
		int a;
		int d;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// Writes to unused indexes must leave the reset box in place.
		write_reg(REG_SPARE_6, 32'h8000_0001);
		write_reg(REG_SPARE_7, 32'hFFFF_FFFF);
		close_writes();
		queue_point(32'sd32768, 32'sd32768, 32'sd32768, 4'd8);
		queue_point(32'sd32767, 32'sd32767, 32'sd32767, 4'd8);
		queue_point(32'sd0, 32'sd0, 32'sd0, 4'd8);
		queue_point(32'sd65535, 32'sd65535, 32'sd65535, 4'd8);
		queue_point(32'sd65536, 32'sd65536, 32'sd65536, 4'd8);
		queue_point(COORD_MIN, COORD_MAX, 32'sd0, 4'd15);
		queue_point(COORD_MAX, COORD_MIN, -32'sd1, 4'd9);
		queue_point(-32'sd1, 32'sd131072, 32'sd12345, 4'd0);
		for (d = 1; d < 15; d++) begin
			if (d != 8 && d != 9) begin
				queue_point(d * 5000, 65535 - d * 5000, d * 3000 + 1, depth_t'(d));
			end
		end
		drain();

		set_box(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
		queue_random_points(100);
		drain();

		steady = 1'b1;
		set_box(32'sd0, 32'sd65536, 32'sd0, 32'sd65536, 32'sd0, 32'sd65536);
		queue_random_points(150);
		drain();
		steady = 1'b0;

		set_box(-32'sd4096, 32'sd200000, 32'sd7, 32'sd9000, -32'sd800000, -32'sd100);
		long_hold_req = 1'b1;
		queue_random_points(100);
		drain();

		for (phase = 0; phase < 5; phase++) begin
			for (a = 0; a < 3; a++) begin
				lo_v[a] = $urandom;
				if (phase % 2 == 0) begin
					hi_v[a] = $urandom;
				end else begin
					hi_v[a] = lo_v[a] + coord_t'($urandom_range(1 << 20));
				end
			end
			set_box(lo_v[0], hi_v[0], lo_v[1], hi_v[1], lo_v[2], hi_v[2]);
			queue_random_points(80);
			drain();
		end

		lo_v[0] = $urandom;
		lo_v[1] = $urandom;
		lo_v[2] = $urandom;
		set_box(lo_v[0], lo_v[0], lo_v[1], lo_v[1], lo_v[2], lo_v[2]);
		queue_random_points(50);
		drain();

		set_box(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN);
		queue_random_points(50);
		drain();

		set_box(COORD_MAX - 32'sd1000, COORD_MAX, COORD_MIN, COORD_MIN + 32'sd1000,
			COORD_MAX - 32'sd65536, COORD_MAX);
		queue_random_points(50);
		drain();

		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
